/* sv/mat3_inverse_assert.svh */
// assertion macros used by the checker file
`ifndef MAT3_INVERSE_ASSERT_SVH
`define MAT3_INVERSE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define MI3_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mat3_inverse check failed");

// consequent holds in the cycle after the antecedent
`define MI3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mat3_inverse check failed");

`endif

/* sv/mi3_pkg.sv */
package mi3_pkg;

    localparam int ELEM_W    = 32;
    localparam int COF_W     = 64;
    localparam int DET_W     = 98;
    localparam int NUM_ELEM  = 9;
    localparam int DIV_STEPS = 32;

    typedef logic signed [ELEM_W-1:0]           elem_t;
    typedef logic signed [COF_W-1:0]            cof_t;
    typedef logic signed [COF_W:0]              part_lo_t;
    typedef logic signed [DET_W-1:0]            det_t;
    typedef logic [DET_W-1:0]                   dmag_t;
    typedef logic [NUM_ELEM-1:0][ELEM_W-1:0]    mat_t;
    typedef logic [NUM_ELEM-1:0][COF_W-1:0]     mag_arr_t;
    typedef logic [NUM_ELEM-1:0][DET_W-1:0]     rem_arr_t;
    typedef logic [NUM_ELEM-1:0][ELEM_W-1:0]    quo_arr_t;

    // per-beat control that rides along the divider
    typedef struct packed {
        mat_t                src;
        logic [NUM_ELEM-1:0] neg;
        logic [NUM_ELEM-1:0] ovf;
        logic                singular;
    } side_t;

    // cofactor k = src[PA]*src[PB] - src[PC]*src[PD], placed as adjugate
    localparam int COF_PA [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_PB [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_PC [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_PD [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // adjugate column 0 entries that pair with first row elements
    localparam int DET_COF [3] = '{0, 3, 6};

    localparam logic [ELEM_W-1:0] POS_LIMIT = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] NEG_LIMIT = {1'b1, {(ELEM_W-1){1'b0}}};

endpackage

/* sv/mi3_divider.sv */
module mi3_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  mi3_pkg::mag_arr_t in_mag,
    input  mi3_pkg::dmag_t   in_dmag,
    input  mi3_pkg::side_t   in_side,
    output logic             out_valid,
    output mi3_pkg::quo_arr_t out_quo,
    output mi3_pkg::side_t   out_side
);

    logic              valid_reg [mi3_pkg::DIV_STEPS];
    mi3_pkg::rem_arr_t rem_reg   [mi3_pkg::DIV_STEPS];
    mi3_pkg::quo_arr_t quo_reg   [mi3_pkg::DIV_STEPS];
    mi3_pkg::dmag_t    dmag_reg  [mi3_pkg::DIV_STEPS];
    mi3_pkg::side_t    side_reg  [mi3_pkg::DIV_STEPS];

    for (genvar s = 0; s < mi3_pkg::DIV_STEPS; s++) begin : g_step
        logic              valid_in;
        mi3_pkg::rem_arr_t rem_in;
        mi3_pkg::quo_arr_t quo_in;
        mi3_pkg::dmag_t    dmag_in;
        mi3_pkg::side_t    side_in;
        mi3_pkg::rem_arr_t rem_shl;
        mi3_pkg::rem_arr_t rem_next;
        mi3_pkg::quo_arr_t quo_next;

        // stage source: front end or previous step
        if (s == 0) begin : g_first
            always_comb
            begin
                valid_in = in_valid;
                dmag_in  = in_dmag;
                side_in  = in_side;
                quo_in   = '0;
                for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
                begin
                    rem_in[k] = {{(mi3_pkg::DET_W - mi3_pkg::COF_W){1'b0}}, in_mag[k]};
                end
            end
        end else begin : g_rest
            always_comb
            begin
                valid_in = valid_reg[s-1];
                dmag_in  = dmag_reg[s-1];
                side_in  = side_reg[s-1];
                quo_in   = quo_reg[s-1];
                rem_in   = rem_reg[s-1];
            end
        end

        // one restoring step per lane
        always_comb
        begin
            for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
            begin
                rem_shl[k] = {rem_in[k][mi3_pkg::DET_W-2:0], 1'b0};
                if (rem_shl[k] >= dmag_in)
                begin
                    rem_next[k] = rem_shl[k] - dmag_in;
                    quo_next[k] = {quo_in[k][mi3_pkg::ELEM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = rem_shl[k];
                    quo_next[k] = {quo_in[k][mi3_pkg::ELEM_W-2:0], 1'b0};
                end
            end
        end

        // step valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_in;
            end
        end

        // step payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                dmag_reg[s] <= dmag_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[mi3_pkg::DIV_STEPS-1];
    assign out_quo   = quo_reg[mi3_pkg::DIV_STEPS-1];
    assign out_side  = side_reg[mi3_pkg::DIV_STEPS-1];

endmodule

/* sv/mat3_inverse.sv */
// 3x3 matrix inverse, signed Q16.16 in and out, adjugate over exact determinant.
// Input channel: in_valid/in_ready carry one matrix (src_r_c) per beat.
// Output channel: out_valid/out_ready carry the inverse (dst_r_c) with the
// singular and saturated flags per beat.
// From input beat to output valid a matrix passes 8 front-end stages
// (products, cofactors, determinant partials and sums, magnitudes, range
// compare), 32 divider stages that each retire one quotient bit for all nine
// lanes, and the output register that rounds off sign and saturation.
// One matrix per cycle while no beat is held; every stage advances together.
// A zero determinant passes the input matrix through with singular set.
// When the receiver holds out_ready low with a beat waiting, in_ready drops in
// the same cycle and the whole pipe freezes; nothing is dropped or repeated.
// Reset clears all valid bits; the pipe comes up empty and ready.
module mat3_inverse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    src_0_0,
    input  logic signed [31:0]    src_0_1,
    input  logic signed [31:0]    src_0_2,
    input  logic signed [31:0]    src_1_0,
    input  logic signed [31:0]    src_1_1,
    input  logic signed [31:0]    src_1_2,
    input  logic signed [31:0]    src_2_0,
    input  logic signed [31:0]    src_2_1,
    input  logic signed [31:0]    src_2_2,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    dst_0_0,
    output logic signed [31:0]    dst_0_1,
    output logic signed [31:0]    dst_0_2,
    output logic signed [31:0]    dst_1_0,
    output logic signed [31:0]    dst_1_1,
    output logic signed [31:0]    dst_1_2,
    output logic signed [31:0]    dst_2_0,
    output logic signed [31:0]    dst_2_1,
    output logic signed [31:0]    dst_2_2,
    output logic                  singular,
    output logic                  saturated
);

    logic en;
    mi3_pkg::mat_t src_mat;

    // stage valids
    logic [7:0] valid_reg;

    // stage payloads
    mi3_pkg::mat_t     mat_reg [7];
    mi3_pkg::cof_t     prod_a_reg [mi3_pkg::NUM_ELEM];
    mi3_pkg::cof_t     prod_b_reg [mi3_pkg::NUM_ELEM];
    mi3_pkg::cof_t     cof_reg [5][mi3_pkg::NUM_ELEM];
    mi3_pkg::part_lo_t part_lo_reg [3];
    mi3_pkg::cof_t     part_hi_reg [3];
    mi3_pkg::det_t     prod_reg [3];
    mi3_pkg::det_t     sum01_reg;
    mi3_pkg::det_t     prod2_reg;
    mi3_pkg::det_t     det_reg;
    mi3_pkg::dmag_t    dmag_reg [2];
    logic              dneg_reg;
    logic              sing_reg;
    mi3_pkg::mag_arr_t mag_reg [2];
    logic [mi3_pkg::NUM_ELEM-1:0] cneg_reg;
    mi3_pkg::side_t    side_reg;

    // next values
    mi3_pkg::cof_t     prod_a_next [mi3_pkg::NUM_ELEM];
    mi3_pkg::cof_t     prod_b_next [mi3_pkg::NUM_ELEM];
    mi3_pkg::cof_t     cof_next [mi3_pkg::NUM_ELEM];
    mi3_pkg::part_lo_t part_lo_next [3];
    mi3_pkg::cof_t     part_hi_next [3];
    mi3_pkg::det_t     prod_next [3];
    mi3_pkg::dmag_t    dmag_next;
    mi3_pkg::mag_arr_t mag_next;
    logic [mi3_pkg::NUM_ELEM-1:0] cneg_next;
    mi3_pkg::side_t    side_next;

    // divider outputs
    logic              div_valid;
    mi3_pkg::quo_arr_t div_quo;
    mi3_pkg::side_t    div_side;

    // output register
    logic              out_valid_reg;
    mi3_pkg::mat_t     dst_reg;
    logic              singular_reg;
    logic              saturated_reg;
    mi3_pkg::mat_t     dst_next;
    logic              saturated_next;
    logic [mi3_pkg::NUM_ELEM-1:0] sat_lane;
    logic [mi3_pkg::ELEM_W-1:0]   limit_lane [mi3_pkg::NUM_ELEM];
    logic [mi3_pkg::ELEM_W-1:0]   clamp_lane [mi3_pkg::NUM_ELEM];

    // whole pipe advances unless a finished beat is held
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign src_mat[0] = src_0_0;
    assign src_mat[1] = src_0_1;
    assign src_mat[2] = src_0_2;
    assign src_mat[3] = src_1_0;
    assign src_mat[4] = src_1_1;
    assign src_mat[5] = src_1_2;
    assign src_mat[6] = src_2_0;
    assign src_mat[7] = src_2_1;
    assign src_mat[8] = src_2_2;

    // stage 1: the eighteen 32x32 products
    always_comb
    begin
        for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
        begin
            prod_a_next[k] = mi3_pkg::cof_t'(mi3_pkg::elem_t'(src_mat[mi3_pkg::COF_PA[k]]))
                           * mi3_pkg::cof_t'(mi3_pkg::elem_t'(src_mat[mi3_pkg::COF_PB[k]]));
            prod_b_next[k] = mi3_pkg::cof_t'(mi3_pkg::elem_t'(src_mat[mi3_pkg::COF_PC[k]]))
                           * mi3_pkg::cof_t'(mi3_pkg::elem_t'(src_mat[mi3_pkg::COF_PD[k]]));
        end
    end

    // stage 2: cofactors
    always_comb
    begin
        for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
        begin
            cof_next[k] = prod_a_reg[k] - prod_b_reg[k];
        end
    end

    // stage 3: first row times adjugate column, split in 32-bit halves
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            part_lo_next[j] = mi3_pkg::part_lo_t'(mi3_pkg::elem_t'(mat_reg[1][j]))
                * $signed({{(mi3_pkg::COF_W - mi3_pkg::ELEM_W + 1){1'b0}},
                           cof_reg[0][mi3_pkg::DET_COF[j]][mi3_pkg::ELEM_W-1:0]});
            part_hi_next[j] = mi3_pkg::cof_t'(mi3_pkg::elem_t'(mat_reg[1][j]))
                * mi3_pkg::cof_t'(mi3_pkg::elem_t'(
                    cof_reg[0][mi3_pkg::DET_COF[j]][mi3_pkg::COF_W-1:mi3_pkg::ELEM_W]));
        end
    end

    // stage 4: join the halves
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod_next[j] = (mi3_pkg::det_t'(part_hi_reg[j]) <<< mi3_pkg::ELEM_W)
                         + mi3_pkg::det_t'(part_lo_reg[j]);
        end
    end

    // stage 7: magnitudes and signs
    always_comb
    begin
        dmag_next = det_reg[mi3_pkg::DET_W-1] ? mi3_pkg::dmag_t'(-det_reg)
                                              : mi3_pkg::dmag_t'(det_reg);
        for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
        begin
            cneg_next[k] = cof_reg[4][k][mi3_pkg::COF_W-1];
            mag_next[k]  = cneg_next[k] ? -cof_reg[4][k] : cof_reg[4][k];
        end
    end

    // stage 8: result signs and quotients that cannot fit 32 bits
    always_comb
    begin
        side_next.src      = mat_reg[6];
        side_next.singular = sing_reg;
        for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
        begin
            side_next.neg[k] = cneg_reg[k] ^ dneg_reg;
            side_next.ovf[k] = {{(mi3_pkg::DET_W - mi3_pkg::COF_W){1'b0}}, mag_reg[0][k]}
                               >= dmag_reg[0];
        end
    end

    // front-end valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[6:0], in_valid};
        end
    end

    // front-end payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg[0] <= src_mat;
            for (int s = 1; s < 7; s++)
            begin
                mat_reg[s] <= mat_reg[s-1];
            end
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            cof_reg[0] <= cof_next;
            for (int s = 1; s < 5; s++)
            begin
                cof_reg[s] <= cof_reg[s-1];
            end
            part_lo_reg <= part_lo_next;
            part_hi_reg <= part_hi_next;
            prod_reg    <= prod_next;
            sum01_reg   <= prod_reg[0] + prod_reg[1];
            prod2_reg   <= prod_reg[2];
            det_reg     <= sum01_reg + prod2_reg;
            dmag_reg[0] <= dmag_next;
            dneg_reg    <= det_reg[mi3_pkg::DET_W-1];
            sing_reg    <= (det_reg == '0);
            mag_reg[0]  <= mag_next;
            cneg_reg    <= cneg_next;
            dmag_reg[1] <= dmag_reg[0];
            mag_reg[1]  <= mag_reg[0];
            side_reg    <= side_next;
        end
    end

    mi3_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_reg[7]),
        .in_mag    (mag_reg[1]),
        .in_dmag   (dmag_reg[1]),
        .in_side   (side_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // clamp, apply sign, pick pass-through for a singular matrix
    always_comb
    begin
        for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
        begin
            limit_lane[k] = div_side.neg[k] ? mi3_pkg::NEG_LIMIT : mi3_pkg::POS_LIMIT;
            sat_lane[k]   = div_side.ovf[k] || (div_quo[k] > limit_lane[k]);
            clamp_lane[k] = sat_lane[k] ? limit_lane[k] : div_quo[k];
            if (div_side.singular)
            begin
                dst_next[k] = div_side.src[k];
            end
            else
            begin
                dst_next[k] = div_side.neg[k] ? -clamp_lane[k] : clamp_lane[k];
            end
        end
        saturated_next = !div_side.singular && (|sat_lane);
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dst_reg       <= dst_next;
            singular_reg  <= div_side.singular;
            saturated_reg <= saturated_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign dst_0_0   = dst_reg[0];
    assign dst_0_1   = dst_reg[1];
    assign dst_0_2   = dst_reg[2];
    assign dst_1_0   = dst_reg[3];
    assign dst_1_1   = dst_reg[4];
    assign dst_1_2   = dst_reg[5];
    assign dst_2_0   = dst_reg[6];
    assign dst_2_1   = dst_reg[7];
    assign dst_2_2   = dst_reg[8];
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

endmodule

/* sv/mi3_checker.sv */
`include "mat3_inverse_assert.svh"

module mi3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] dst_0_0,
    input logic        singular,
    input logic        saturated
);

    // a held beat stays valid and keeps its dst_0_0 payload
    `MI3_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(dst_0_0))

    // a pass-through beat is never flagged as clamped
    `MI3_ASSERT_SAME(a_flags, out_valid && singular, !saturated)

    // the input side stalls exactly when a finished beat is held
    `MI3_ASSERT_SAME(a_ready, in_valid || !in_valid, in_ready == (!out_valid || out_ready))

endmodule

bind mat3_inverse mi3_checker u_mi3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dst_0_0   (dst_0_0),
    .singular  (singular),
    .saturated (saturated)
);
